// ===== design/urla_pkg.sv =====
// ----------------------------------------------------------------------------
// urla_pkg - shared definitions for the UART receive ring line assembler
// Field widths, command and status codes, framing characters and the
// default sizes of the ring and the line buffer.
// ----------------------------------------------------------------------------
package urla_pkg;

  // Payload widths
  localparam int DATA_W   = 8;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 7;

  // Default storage sizes
  localparam int RING_DEPTH_DEF    = 256;
  localparam int LINE_CAPACITY_DEF = 64;

  // Command codes on the input channel
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_POLL = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_NO_LINE   = 2'd0,
    ST_LINE_BYTE = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_BAD_ARG   = 2'd3
  } status_t;

  // Framing characters
  localparam logic [DATA_W-1:0] CH_LF = 8'h0A;
  localparam logic [DATA_W-1:0] CH_CR = 8'h0D;

endpackage

// ===== design/uart_rx_ring_line_assembler.sv =====
// ----------------------------------------------------------------------------
// uart_rx_ring_line_assembler - UART receive ring with line assembler
// Received bytes go into a ring FIFO; a poll drains the ring into a line
// buffer and, on a line feed, returns the line one byte per transfer.
//
//   Channel  Ports                                         Direction
//   in       in_valid in_stall in_cmd in_rx_data in_max_len  item in
//   out      out_valid out_stall out_status out_line_byte    result out
//            out_line_length out_last
//
// A byte item is one ring write. A poll drains the ring entry by entry
// (ring read, then classify and line-buffer write), then delivers each line
// byte (line-buffer read, output load). When no line feed is found, a final
// empty check ends the drain. A poll that delivers no line bytes loads one
// status result instead. A stalled output holds the poll before each load.
// Both memories have a registered read.
// Reset clears the pointers, the fill count and the control; memory
// contents are not cleared. in_stall stays high while a poll is in work.
// ----------------------------------------------------------------------------
module uart_rx_ring_line_assembler #(
  parameter int RING_DEPTH    = urla_pkg::RING_DEPTH_DEF,
  parameter int LINE_CAPACITY = urla_pkg::LINE_CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_cmd,
  input  logic [urla_pkg::DATA_W-1:0]   in_rx_data,
  input  logic [urla_pkg::DATA_W-1:0]   in_max_len,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [urla_pkg::STATUS_W-1:0] out_status,
  output logic [urla_pkg::DATA_W-1:0]   out_line_byte,
  output logic [urla_pkg::LEN_W-1:0]    out_line_length,
  output logic                          out_last
);

  import urla_pkg::*;

  localparam int PW  = $clog2(RING_DEPTH);
  localparam int LFW = $clog2(LINE_CAPACITY);

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_DRAIN_RD  = 6'b000010,
    S_DRAIN_CHK = 6'b000100,
    S_EMIT_RD   = 6'b001000,
    S_EMIT_OUT  = 6'b010000,
    S_RESP      = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [PW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [LFW-1:0]      fill_r, fill_nxt;
  logic [LFW-1:0]      emit_len_r, emit_len_nxt;
  logic [LFW-1:0]      emit_idx_r, emit_idx_nxt;
  logic [DATA_W-1:0]   max_len_r, max_len_nxt;
  status_t             resp_status_r, resp_status_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [DATA_W-1:0]   out_byte_r, out_byte_nxt;
  logic [LEN_W-1:0]    out_len_r, out_len_nxt;
  logic                out_last_r, out_last_nxt;

  logic                in_xfer;
  logic                out_free;
  logic [PW-1:0]       wr_ptr_inc;
  logic [PW-1:0]       rd_ptr_inc;
  logic                ring_full;
  logic                ring_empty;

  logic                ring_wr_en;
  logic                ring_rd_en;
  logic [DATA_W-1:0]   ring_rd_data;
  logic                line_wr_en;
  logic                line_rd_en;
  logic [DATA_W-1:0]   line_rd_data;

  logic [DATA_W-1:0]   max_m1;
  logic [DATA_W-1:0]   fill_ext;
  logic [DATA_W-1:0]   cut_len;
  logic                emit_last;

  // Ring FIFO storage
  urla_ram #(
    .WIDTH (DATA_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_wr_en),
    .wr_addr (wr_ptr_r),
    .wr_data (in_rx_data),
    .rd_en   (ring_rd_en),
    .rd_addr (rd_ptr_r),
    .rd_data (ring_rd_data)
  );

  // Line buffer storage
  urla_ram #(
    .WIDTH (DATA_W),
    .DEPTH (LINE_CAPACITY)
  ) u_line (
    .clk     (clk),
    .wr_en   (line_wr_en),
    .wr_addr (fill_r),
    .wr_data (ring_rd_data),
    .rd_en   (line_rd_en),
    .rd_addr (emit_idx_r),
    .rd_data (line_rd_data)
  );

  // Handshake and pointer arithmetic
  assign in_stall   = (state_r != S_IDLE);
  assign in_xfer    = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign wr_ptr_inc = (wr_ptr_r == PW'(RING_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_inc = (rd_ptr_r == PW'(RING_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
  assign ring_full  = (wr_ptr_inc == rd_ptr_r);
  assign ring_empty = (rd_ptr_r == wr_ptr_r);

  // Memory port controls
  assign ring_wr_en = in_xfer && (in_cmd == CMD_BYTE) && !ring_full;
  assign ring_rd_en = (state_r == S_DRAIN_RD) && !ring_empty;
  assign line_wr_en = (state_r == S_DRAIN_CHK) && (ring_rd_data != CH_LF) &&
                      (ring_rd_data != CH_CR) &&
                      (fill_r < LFW'(LINE_CAPACITY - 1));
  assign line_rd_en = (state_r == S_EMIT_RD);

  // Line length after the cut to max_len - 1
  assign max_m1    = max_len_r - 1'b1;
  assign fill_ext  = DATA_W'(fill_r);
  assign cut_len   = (fill_ext > max_m1) ? max_m1 : fill_ext;
  assign emit_last = ((emit_idx_r + 1'b1) == emit_len_r);

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    wr_ptr_nxt      = wr_ptr_r;
    rd_ptr_nxt      = rd_ptr_r;
    fill_nxt        = fill_r;
    emit_len_nxt    = emit_len_r;
    emit_idx_nxt    = emit_idx_r;
    max_len_nxt     = max_len_r;
    resp_status_nxt = resp_status_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_byte_nxt    = out_byte_r;
    out_len_nxt     = out_len_r;
    out_last_nxt    = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_cmd == CMD_BYTE) begin
            // store the byte unless the ring is full
            if (!ring_full) begin
              wr_ptr_nxt = wr_ptr_inc;
            end
          end else if (in_max_len == '0) begin
            resp_status_nxt = ST_BAD_ARG;
            state_nxt       = S_RESP;
          end else begin
            max_len_nxt = in_max_len;
            state_nxt   = S_DRAIN_RD;
          end
        end
      end
      S_DRAIN_RD: begin
        // fetch the next ring entry, or report no line when drained
        if (ring_empty) begin
          resp_status_nxt = ST_NO_LINE;
          state_nxt       = S_RESP;
        end else begin
          rd_ptr_nxt = rd_ptr_inc;
          state_nxt  = S_DRAIN_CHK;
        end
      end
      S_DRAIN_CHK: begin
        // classify the fetched byte
        if (ring_rd_data == CH_LF) begin
          fill_nxt     = '0;
          emit_len_nxt = LFW'(cut_len);
          emit_idx_nxt = '0;
          if (cut_len == '0) begin
            resp_status_nxt = ST_EMPTY;
            state_nxt       = S_RESP;
          end else begin
            state_nxt = S_EMIT_RD;
          end
        end else begin
          if (line_wr_en) begin
            fill_nxt = fill_r + 1'b1;
          end
          state_nxt = S_DRAIN_RD;
        end
      end
      S_EMIT_RD: begin
        state_nxt = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        // load one line byte into the output register
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_LINE_BYTE;
          out_byte_nxt   = line_rd_data;
          out_len_nxt    = LEN_W'(emit_len_r);
          out_last_nxt   = emit_last;
          if (emit_last) begin
            state_nxt = S_IDLE;
          end else begin
            emit_idx_nxt = emit_idx_r + 1'b1;
            state_nxt    = S_EMIT_RD;
          end
        end
      end
      S_RESP: begin
        // load the single status result
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = resp_status_r;
          out_byte_nxt   = '0;
          out_len_nxt    = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    emit_len_r    <= emit_len_nxt;
    emit_idx_r    <= emit_idx_nxt;
    max_len_r     <= max_len_nxt;
    resp_status_r <= resp_status_nxt;
    out_status_r  <= out_status_nxt;
    out_byte_r    <= out_byte_nxt;
    out_len_r     <= out_len_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_line_byte   = out_byte_r;
  assign out_line_length = out_len_r;
  assign out_last        = out_last_r;

endmodule

// ===== design/urla_ram.sv =====
// ----------------------------------------------------------------------------
// urla_ram - generic simple dual-port RAM
// One write port, one read port with a registered read.
// Read data holds while rd_en is low.
// ----------------------------------------------------------------------------
module urla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== tb/tb_uart_rx_ring_line_assembler.sv =====
// ----------------------------------------------------------------------------
// tb_uart_rx_ring_line_assembler - testbench for the UART receive line assembler
// Feeds received bytes and line polls through the input channel, predicts every
// result with a cycle-free model of the ring and line buffer, and checks each
// result transfer field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_uart_rx_ring_line_assembler;
  timeunit 1ns;
  timeprecision 1ps;

  import urla_pkg::*;

  localparam int RING_DEPTH     = RING_DEPTH_DEF;
  localparam int LINE_CAPACITY  = LINE_CAPACITY_DEF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 200;
  localparam int IDLE_PCT       = 30;

  // One input transfer; settle holds it back until all results are in
  typedef struct {
    logic              cmd;
    logic [DATA_W-1:0] rx_data;
    logic [DATA_W-1:0] max_len;
    bit                settle;
  } ring_item_t;

  typedef struct {
    status_t           status;
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  len;
    logic              last;
  } line_result_t;

  logic                clk             = 1'b0;
  logic                rst_n           = 1'b0;
  logic                in_valid        = 1'b0;
  logic                in_cmd          = CMD_BYTE;
  logic [DATA_W-1:0]   in_rx_data      = '0;
  logic [DATA_W-1:0]   in_max_len      = '0;
  logic                out_stall       = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [DATA_W-1:0]   out_line_byte;
  logic [LEN_W-1:0]    out_line_length;
  logic                out_last;

  ring_item_t   pending_items[$];
  line_result_t due_results[$];

  // Model state: ring FIFO and line accumulator
  logic [DATA_W-1:0] ring_mem [RING_DEPTH];
  logic [DATA_W-1:0] line_buf [LINE_CAPACITY];
  int                wr_ptr    = 0;
  int                rd_ptr    = 0;
  int                line_fill = 0;

  int n_err          = 0;
  int n_in_done      = 0;
  int quiet_cycles   = 0;
  bit timed_out      = 1'b0;

  uart_rx_ring_line_assembler uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_rx_data      (in_rx_data),
    .in_max_len      (in_max_len),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_line_byte   (out_line_byte),
    .out_line_length (out_line_length),
    .out_last        (out_last)
  );

  always #2 clk = ~clk;

  // No idling on either side while this window of transfers goes by
  function automatic bit calm_window();
    return (n_in_done >= 40) && (n_in_done < 90);
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    n_err++;
  endtask

  task automatic queue_result(input status_t st, input logic [DATA_W-1:0] data,
                              input int len, input logic last);
    line_result_t r;
    r.status = st;
    r.data   = data;
    r.len    = len[LEN_W-1:0];
    r.last   = last;
    due_results.push_back(r);
  endtask

  // Advance the ring and line model by one accepted transfer
  task automatic apply_ring_item(input logic cmd, input logic [DATA_W-1:0] data,
                                 input logic [DATA_W-1:0] mlen);
    int                nxt;
    int                n;
    int                lim;
    logic [DATA_W-1:0] c;
    if (cmd == CMD_BYTE) begin
      // Drop the byte when the ring is full
      nxt = (wr_ptr + 1) % RING_DEPTH;
      if (nxt != rd_ptr) begin
        ring_mem[wr_ptr] = data;
        wr_ptr = nxt;
      end
      return;
    end
    if (mlen == 0) begin
      queue_result(ST_BAD_ARG, '0, 0, 1'b1);
      return;
    end
    lim = int'(mlen) - 1;
    while (rd_ptr != wr_ptr) begin
      c = ring_mem[rd_ptr];
      rd_ptr = (rd_ptr + 1) % RING_DEPTH;
      if (c == CH_LF) begin
        n = (line_fill > lim) ? lim : line_fill;
        line_fill = 0;
        if (n == 0) begin
          queue_result(ST_EMPTY, '0, 0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++)
            queue_result(ST_LINE_BYTE, line_buf[i], n, (i + 1 == n));
        end
        return;
      end
      // Skip carriage returns, keep the head of an overlong line
      if (c != CH_CR && line_fill < LINE_CAPACITY - 1) begin
        line_buf[line_fill] = c;
        line_fill++;
      end
    end
    queue_result(ST_NO_LINE, '0, 0, 1'b1);
  endtask

  // Driver: present queued items, hold while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_ring_item(in_cmd, in_rx_data, in_max_len);
        n_in_done++;
      end
      if (!(in_valid && in_stall)) begin
        if (pending_items.size() > 0
            && !(pending_items[0].settle && due_results.size() != 0)
            && (calm_window() || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid   <= 1'b1;
          in_cmd     <= pending_items[0].cmd;
          in_rx_data <= pending_items[0].rx_data;
          in_max_len <= pending_items[0].max_len;
          void'(pending_items.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer against the oldest prediction
  always @(posedge clk) begin
    line_result_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          flag_error($sformatf("unexpected result status=%0d byte=%02h len=%0d last=%0b",
                               out_status, out_line_byte, out_line_length, out_last));
        end else begin
          e = due_results.pop_front();
          if (out_status !== e.status)
            flag_error($sformatf("status got %0d want %0d", out_status, e.status));
          if (out_line_byte !== e.data)
            flag_error($sformatf("line_byte got %02h want %02h", out_line_byte, e.data));
          if (out_line_length !== e.len)
            flag_error($sformatf("line_length got %0d want %0d", out_line_length, e.len));
          if (out_last !== e.last)
            flag_error($sformatf("last got %0b want %0b", out_last, e.last));
        end
      end
      out_stall <= !calm_window() && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Watchdog: count cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      timed_out <= 1'b1;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_item(input logic cmd, input logic [DATA_W-1:0] data,
                          input logic [DATA_W-1:0] mlen, input bit settle);
    ring_item_t it;
    it.cmd     = cmd;
    it.rx_data = data;
    it.max_len = mlen;
    it.settle  = settle;
    pending_items.push_back(it);
  endtask

  task automatic add_byte(input logic [DATA_W-1:0] data);
    add_item(CMD_BYTE, data, DATA_W'($urandom_range(255)), 1'b0);
  endtask

  task automatic add_poll(input logic [DATA_W-1:0] mlen);
    add_item(CMD_POLL, DATA_W'($urandom_range(255)), mlen, 1'b0);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++)
      add_byte(s[i]);
  endtask

  // Random line character: never a line feed, now and then a carriage return
  function automatic logic [DATA_W-1:0] line_char();
    logic [DATA_W-1:0] c;
    c = DATA_W'($urandom_range(255));
    if ($urandom_range(9) == 0) c = CH_CR;
    if (c == CH_LF) c = 8'h20;
    return c;
  endfunction

  function automatic logic [DATA_W-1:0] pick_max_len();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 8'd0;
    if (r < 20) return DATA_W'($urandom_range(3, 1));
    if (r < 35) return 8'd255;
    return DATA_W'($urandom_range(255, 1));
  endfunction

  initial begin
    int  count;
    int  r;
    int  n;
    int  start;
    bit  settled;

    // Directed: empty poll, bad argument, empty line, extremes, cuts, two lines
    add_poll(8'd1);
    add_poll(8'd0);
    add_byte(CH_LF);
    add_poll(8'd5);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(CH_CR);
    add_byte(CH_LF);
    add_poll(8'd255);
    add_text("AB");
    add_poll(8'd3);
    add_text("C\n");
    add_poll(8'd0);
    add_poll(8'd3);
    add_text("XY\n");
    add_poll(8'd1);
    add_text("P\nQ\n");
    add_poll(8'd9);
    add_poll(8'd9);

    // Random: mostly well-formed lines, some stray polls and raw bytes
    count   = 0;
    settled = 1'b0;
    while (count < 20) begin
      start = pending_items.size();
      r = $urandom_range(99);
      if (!settled && count >= 10) begin
        // Hold the sender until every pending result has arrived
        add_item(CMD_POLL, DATA_W'($urandom_range(255)), 8'd255, 1'b1);
        settled = 1'b1;
      end else if (r < 70) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(8);
        for (int i = 0; i < n; i++) begin
          add_byte(line_char());
          if ($urandom_range(19) == 0) add_poll(pick_max_len());
        end
        add_byte(CH_LF);
        add_poll(pick_max_len());
      end else if (r < 85) begin
        add_poll(pick_max_len());
      end else begin
        add_byte(DATA_W'($urandom_range(255)));
      end
      count += pending_items.size() - start;
    end

    // Overlong line: keep its head, drop the tail up to the line feed
    for (int i = 0; i < LINE_CAPACITY; i++)
      add_byte(line_char());
    add_byte(CH_LF);
    add_poll(8'd255);
    add_text("end\r\n");
    add_poll(pick_max_len());

    // Release reset once the stimulus is queued
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for all transfers and results, then watch for strays
    while (!(pending_items.size() == 0 && !in_valid && due_results.size() == 0)
           && !timed_out)
      @(posedge clk);
    if (!timed_out) repeat (TAIL_CYCLES) @(posedge clk);
    if (due_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", due_results.size()));

    if (!timed_out && n_err == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
